FILE: design/dld_pkg.sv
// Shared constants and types for the decimal long division digit unit.
package dld_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int MAX_DIGITS    = 31999;

    localparam int VALUE_W     = 32;
    localparam int LEN_W       = 15;
    localparam int DIGITS_W    = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W      = $clog2(OPERAND_WIDTH + 1);
    localparam int DIGIT_STEPS = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_NO_RUN   = 2'd2
    } t_status;

    typedef struct packed {
        logic    load_start;
        logic    load_digit;
        logic    step;
        logic    out_load;
        t_status status;
        logic    is_integer_part;
        logic    point_follows;
        logic    last;
    } t_dld_cmd;

    typedef struct packed {
        logic div_zero;
    } t_dld_stat;

endpackage

FILE: design/dld_ctrl.sv
// Controller: request sequencing, step counting and digit bookkeeping.
module dld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [14:0]       i_length,
    output logic              o_valid,
    input  logic              i_stall,
    input  dld_pkg::t_dld_stat i_stat,
    output dld_pkg::t_dld_cmd  o_cmd
);
    import dld_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_count, n_count;
    logic [DIGITS_W-1:0] r_digits, n_digits;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic                r_is_int, n_is_int;
    logic                r_pf, n_pf;
    logic                r_last, n_last;

    logic                load_start, load_digit, step, out_load;
    logic [LEN_W-1:0]    len_sat;
    logic [DIGITS_W-1:0] start_left;
    logic [DIGITS_W-1:0] next_left;

    // Clamp the requested length to 1..MAX_DIGITS
    always_comb begin
        len_sat = i_length;
        if (i_length == '0) begin
            len_sat = LEN_W'(1);
        end else if (i_length > LEN_W'(MAX_DIGITS)) begin
            len_sat = LEN_W'(MAX_DIGITS);
        end
        start_left = DIGITS_W'(len_sat - LEN_W'(1));
        next_left  = r_digits - DIGITS_W'(1);
    end

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_digits    = r_digits;
        n_status    = r_status;
        n_is_int    = r_is_int;
        n_pf        = r_pf;
        n_last      = r_last;
        load_start  = 1'b0;
        load_digit  = 1'b0;
        step        = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_func) begin
                        if (i_stat.div_zero) begin
                            n_status = ST_DIV_ZERO;
                            n_digits = '0;
                            n_is_int = 1'b0;
                            n_pf     = 1'b0;
                            n_last   = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            load_start = 1'b1;
                            n_status   = ST_OK;
                            n_digits   = start_left;
                            n_is_int   = 1'b1;
                            n_pf       = (start_left != '0);
                            n_last     = (start_left == '0);
                            n_count    = STEP_W'(OPERAND_WIDTH);
                            n_state    = S_CALC;
                        end
                    end else if (r_digits == '0) begin
                        n_status = ST_NO_RUN;
                        n_is_int = 1'b0;
                        n_pf     = 1'b0;
                        n_last   = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        load_digit = 1'b1;
                        n_status   = ST_OK;
                        n_digits   = next_left;
                        n_is_int   = 1'b0;
                        n_pf       = 1'b0;
                        n_last     = (next_left == '0);
                        n_count    = STEP_W'(DIGIT_STEPS);
                        n_state    = S_CALC;
                    end
                end
            end
            S_CALC: begin
                step    = 1'b1;
                n_count = r_count - STEP_W'(1);
                if (r_count == STEP_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_digits    <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_is_int    <= 1'b0;
            r_pf        <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_digits    <= n_digits;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_is_int    <= n_is_int;
            r_pf        <= n_pf;
            r_last      <= n_last;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    assign o_cmd.load_start      = load_start;
    assign o_cmd.load_digit      = load_digit;
    assign o_cmd.step            = step;
    assign o_cmd.out_load        = out_load;
    assign o_cmd.status          = r_status;
    assign o_cmd.is_integer_part = r_is_int;
    assign o_cmd.point_follows   = r_pf;
    assign o_cmd.last            = r_last;

endmodule

FILE: design/dld_dpath.sv
// Datapath: operand magnitudes, shared restoring divider and result registers.
module dld_dpath (
    input  logic                i_clk,
    input  logic [31:0]         i_dividend,
    input  logic [31:0]         i_divisor,
    input  dld_pkg::t_dld_cmd   i_cmd,
    output dld_pkg::t_dld_stat  o_stat,
    output logic [1:0]          o_status,
    output logic                o_negative,
    output logic [31:0]         o_value,
    output logic                o_is_integer_part,
    output logic                o_point_follows,
    output logic                o_last
);
    import dld_pkg::*;

    localparam int OW = OPERAND_WIDTH;

    logic [OW-1:0]      r_rem;
    logic [OW-1:0]      r_sh;
    logic [OW-1:0]      r_div;
    logic               r_sign;

    logic [1:0]         r_status;
    logic               r_negative;
    logic [VALUE_W-1:0] r_value;
    logic               r_is_int;
    logic               r_pf;
    logic               r_last;

    logic [OW-1:0]      a_raw, b_raw, a_mag, b_mag;
    logic               a_neg, b_neg;
    logic [OW+3:0]      scaled;
    logic [OW:0]        shifted;
    logic [OW:0]        diff;
    logic               ge;
    logic               ok;

    // Split operands into sign and magnitude
    always_comb begin
        a_raw = i_dividend[OW-1:0];
        b_raw = i_divisor[OW-1:0];
        a_neg = a_raw[OW-1];
        b_neg = b_raw[OW-1];
        a_mag = a_neg ? (~a_raw + OW'(1)) : a_raw;
        b_mag = b_neg ? (~b_raw + OW'(1)) : b_raw;
    end

    assign o_stat.div_zero = (b_raw == '0);

    // Ten times the remainder, and one restoring step
    always_comb begin
        scaled  = ((OW + 4)'(r_rem) << 3) + ((OW + 4)'(r_rem) << 1);
        shifted = {r_rem, r_sh[OW-1]};
        ge      = (shifted >= {1'b0, r_div});
        diff    = shifted - {1'b0, r_div};
    end

    // Load operands, then shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_rem  <= '0;
            r_sh   <= a_mag;
            r_div  <= b_mag;
            r_sign <= a_neg ^ b_neg;
        end else if (i_cmd.load_digit) begin
            r_rem <= scaled[OW+3:4];
            r_sh  <= {scaled[3:0], {(OW - 4){1'b0}}};
        end else if (i_cmd.step) begin
            r_rem <= ge ? diff[OW-1:0] : shifted[OW-1:0];
            r_sh  <= {r_sh[OW-2:0], ge};
        end
    end

    assign ok = (i_cmd.status == ST_OK);

    // Capture the result request
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status   <= i_cmd.status;
            r_negative <= ok & r_sign;
            if (!ok) begin
                r_value <= '0;
            end else if (i_cmd.is_integer_part) begin
                r_value <= VALUE_W'(r_sh);
            end else begin
                r_value <= VALUE_W'(r_sh[3:0]);
            end
            r_is_int <= i_cmd.is_integer_part;
            r_pf     <= i_cmd.point_follows;
            r_last   <= i_cmd.last;
        end
    end

    assign o_status          = r_status;
    assign o_negative        = r_negative;
    assign o_value           = r_value;
    assign o_is_integer_part = r_is_int;
    assign o_point_follows   = r_pf;
    assign o_last            = r_last;

endmodule

FILE: design/decimal_long_division_digits_unit.sv
// Top level of the decimal long division digit unit.
//
// Input channel (i_valid / o_stall): a request with i_func = 0 starts a
// division of i_dividend by i_divisor and asks for i_length digits in all;
// a request with i_func = 1 asks for the next fractional digit.
// Output channel (o_valid / i_stall): one result per request. The first
// result of a run carries the integer quotient magnitude, later ones one
// decimal digit each; o_last marks the final digit of the run.
// A start request runs the 32 one-bit steps of the shared restoring
// divider, then result capture; a digit request runs four divider
// steps, then capture. Error results (zero divisor, digit with no run)
// skip the divider and are captured directly.
// The next request is accepted the cycle after the result is captured,
// while that result may still wait in the output register.
// When the receiver stalls, the result holds and a finished computation
// waits before it is captured; o_stall stays high meanwhile.
// Synchronous reset clears all control state and ends any run.
module decimal_long_division_digits_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  logic [14:0] i_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_negative,
    output logic [31:0] o_value,
    output logic        o_is_integer_part,
    output logic        o_point_follows,
    output logic        o_last
);
    import dld_pkg::*;

    t_dld_cmd  cmd;
    t_dld_stat stat;

    dld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_func   (i_func),
        .i_length (i_length),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    dld_dpath u_dpath (
        .i_clk             (i_clk),
        .i_dividend        (i_dividend),
        .i_divisor         (i_divisor),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_negative        (o_negative),
        .o_value           (o_value),
        .o_is_integer_part (o_is_integer_part),
        .o_point_follows   (o_point_follows),
        .o_last            (o_last)
    );

endmodule
